### hw/rtl/sparse_morph_target_blend_top_assert.svh
// assertion macros for the morph blend block
`ifndef SPARSE_MORPH_TARGET_BLEND_TOP_ASSERT_SVH
`define SPARSE_MORPH_TARGET_BLEND_TOP_ASSERT_SVH

// same-cycle implication
`define SMTB_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SMTB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/smtb_pkg.sv
// ----------------------------------------------------------------------------
// smtb_pkg
// Types and constants shared by the sparse morph target blend block.
// ----------------------------------------------------------------------------
`default_nettype none

package smtb_pkg;

	localparam int STREAM_WORDS = 4096;
	localparam int STREAM_AW    = $clog2(STREAM_WORDS);

	localparam int CFG_IW = 2;

	typedef enum logic [1:0] {
		KIND_WR_A    = 2'd0,
		KIND_WR_B    = 2'd1,
		KIND_BASE    = 2'd2,
		KIND_RESTART = 2'd3
	} kind_t;

	typedef enum logic [CFG_IW-1:0] {
		REG_WEIGHT_B     = 2'd0,
		REG_FIRST_VERTEX = 2'd1
	} cfg_reg_t;

	typedef struct packed {
		kind_t              kind;
		logic [11:0]        address;
		logic [15:0]        word;
		logic signed [15:0] base_x;
		logic signed [15:0] base_y;
		logic signed [15:0] base_z;
		logic               chunk_end;
	} item_t;

	typedef struct packed {
		logic [15:0] out_x;
		logic [15:0] out_y;
		logic [15:0] out_z;
	} blend_t;

	localparam logic [12:0] IDX_MASK   = 13'h1fff;
	localparam logic [17:0] WEIGHT_ONE = 18'h10000;

endpackage

`default_nettype wire

### hw/rtl/sparse_morph_target_blend_top.sv
// ----------------------------------------------------------------------------
// sparse_morph_target_blend_top
// Two sparse delta stream memories blended onto incoming base vertices.
// ----------------------------------------------------------------------------
// Usage:
//   item channel (item_valid / item_stall / item) carries stream word writes
//   for memory A or B, base vertices, and restart requests. cfg channel
//   (cfg_valid / cfg_ready / cfg_index / cfg_data) sets weight_b and
//   first_vertex; cfg_ready is always high, write it only while idle.
//   blend channel (blend_valid / blend_stall / blend) returns one blended
//   vertex per base vertex request.
// Sequence:
//   stream writes and restarts are done when accepted. A base vertex runs a
//   header read, one read slot per component on each memory port, a final add
//   and the output load, which waits while the output register is held, before
//   the next request is taken. The result is valid the cycle after that load.
// Reset: read pointers, vertex position, configuration registers and output
//   valid clear; the stream memories keep undefined contents until written.
// Stall: the output register holds its result under blend_stall; a further
//   request is still taken and runs until it needs the output register.
`default_nettype none

module sparse_morph_target_blend_top
	import smtb_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              item_valid,
	output      logic              item_stall,
	input  wire item_t             item,
	input  wire logic              cfg_valid,
	output      logic              cfg_ready,
	input  wire logic [CFG_IW-1:0] cfg_index,
	input  wire logic [16:0]       cfg_data,
	output      logic              blend_valid,
	input  wire logic              blend_stall,
	output      blend_t            blend
);

	`include "sparse_morph_target_blend_top_assert.svh"

	typedef enum logic [2:0] {
		S_IDLE,
		S_HDR,
		S_X,
		S_Y,
		S_Z,
		S_ADD,
		S_FIN
	} state_t;

	state_t state_q;

	logic [16:0]          weight_b_q;
	logic [15:0]          first_vertex_q;
	logic [STREAM_AW-1:0] rp_a_q, rp_b_q;
	logic [15:0]          vpos_q;

	logic [15:0] mem_a [STREAM_WORDS];
	logic [15:0] mem_b [STREAM_WORDS];
	logic [15:0] rd_a_q, rd_b_q;
	logic [STREAM_AW-1:0] rd_addr_a, rd_addr_b;

	logic item_acc, wr_a, wr_b, base_acc, restart_acc, cfg_acc, out_free;

	logic [STREAM_AW-1:0] ptr_a_q, ptr_b_q;
	logic [2:0]           flags_a_q, flags_b_q;
	logic                 use_a_q, use_b_q;
	logic signed [15:0]   base_x_q, base_y_q, base_z_q;
	logic                 chunk_end_q;

	logic signed [17:0] pos, ia, ib, wa, wb;
	logic               use_a, use_b;

	logic [1:0]         comp;
	logic               take_a, take_b;
	logic signed [15:0] da, db, base_sel;
	logic signed [33:0] pa_full, pb_full;

	logic [31:0]        prod_a_s1, prod_b_s1;
	logic [15:0]        base_s1;
	logic [1:0]         comp_s1;
	logic [31:0]        sum;
	logic [15:0]        comp_res;
	logic [2:0][15:0]   res_q;

	assign item_stall  = (state_q != S_IDLE);
	assign item_acc    = item_valid && !item_stall;
	assign wr_a        = item_acc && (item.kind == KIND_WR_A);
	assign wr_b        = item_acc && (item.kind == KIND_WR_B);
	assign base_acc    = item_acc && (item.kind == KIND_BASE);
	assign restart_acc = item_acc && (item.kind == KIND_RESTART);
	assign cfg_ready   = 1'b1;
	assign cfg_acc     = cfg_valid && cfg_ready;
	assign out_free    = !blend_valid || !blend_stall;

	// stream memories
	always_ff @(posedge clk) begin
		if (wr_a) begin
			mem_a[item.address[STREAM_AW-1:0]] <= item.word;
		end
		rd_a_q <= mem_a[rd_addr_a];
	end

	always_ff @(posedge clk) begin
		if (wr_b) begin
			mem_b[item.address[STREAM_AW-1:0]] <= item.word;
		end
		rd_b_q <= mem_b[rd_addr_b];
	end

	// header decode
	assign pos = $signed({2'b00, vpos_q});
	assign ia  = $signed({5'b00000, rd_a_q[12:0] & IDX_MASK}) - $signed({2'b00, first_vertex_q});
	assign ib  = $signed({5'b00000, rd_b_q[12:0] & IDX_MASK}) - $signed({2'b00, first_vertex_q});

	always_comb begin
		use_a = (pos >= ia);
		if (use_a) begin
			use_b = (pos == ib);
		end else begin
			use_b = (pos >= ib);
		end
	end

	// component slot and read addresses
	always_comb begin
		comp = 2'd0;
		case (state_q)
			S_Y:     comp = 2'd1;
			S_Z:     comp = 2'd2;
			default: comp = 2'd0;
		endcase
	end

	assign take_a = flags_a_q[comp];
	assign take_b = flags_b_q[comp];

	always_comb begin
		rd_addr_a = rp_a_q;
		rd_addr_b = rp_b_q;
		case (state_q)
			S_HDR: begin
				rd_addr_a = rp_a_q + STREAM_AW'(1);
				rd_addr_b = rp_b_q + STREAM_AW'(1);
			end
			S_X, S_Y, S_Z: begin
				rd_addr_a = ptr_a_q + STREAM_AW'(take_a);
				rd_addr_b = ptr_b_q + STREAM_AW'(take_b);
			end
			default: begin
				rd_addr_a = rp_a_q;
				rd_addr_b = rp_b_q;
			end
		endcase
	end

	// blend arithmetic
	assign wb = $signed({1'b0, weight_b_q});
	assign wa = $signed(WEIGHT_ONE) - wb;
	assign da = take_a ? $signed(rd_a_q) : 16'sd0;
	assign db = take_b ? $signed(rd_b_q) : 16'sd0;
	assign pa_full = da * wa;
	assign pb_full = db * wb;

	always_comb begin
		case (comp)
			2'd1:    base_sel = base_y_q;
			2'd2:    base_sel = base_z_q;
			default: base_sel = base_x_q;
		endcase
	end

	assign sum      = prod_a_s1 + prod_b_s1;
	assign comp_res = sum[31:16] + base_s1;

	// datapath registers
	always_ff @(posedge clk) begin
		if (base_acc) begin
			base_x_q    <= item.base_x;
			base_y_q    <= item.base_y;
			base_z_q    <= item.base_z;
			chunk_end_q <= item.chunk_end;
		end
		if (state_q == S_HDR) begin
			use_a_q   <= use_a;
			use_b_q   <= use_b;
			flags_a_q <= rd_a_q[15:13] & {3{use_a}};
			flags_b_q <= rd_b_q[15:13] & {3{use_b}};
			ptr_a_q   <= rp_a_q + STREAM_AW'(1);
			ptr_b_q   <= rp_b_q + STREAM_AW'(1);
		end
		if (state_q == S_X || state_q == S_Y || state_q == S_Z) begin
			ptr_a_q   <= ptr_a_q + STREAM_AW'(take_a);
			ptr_b_q   <= ptr_b_q + STREAM_AW'(take_b);
			prod_a_s1 <= pa_full[31:0];
			prod_b_s1 <= pb_full[31:0];
			base_s1   <= base_sel;
			comp_s1   <= comp;
		end
		if (state_q == S_Y || state_q == S_Z || state_q == S_ADD) begin
			res_q[comp_s1] <= comp_res;
		end
	end

	// control, configuration and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			weight_b_q     <= '0;
			first_vertex_q <= '0;
			rp_a_q         <= '0;
			rp_b_q         <= '0;
			vpos_q         <= '0;
			blend_valid    <= 1'b0;
			blend          <= '0;
		end else begin
			if (cfg_acc) begin
				unique case (cfg_index)
					REG_WEIGHT_B:     weight_b_q <= cfg_data;
					REG_FIRST_VERTEX: first_vertex_q <= cfg_data[15:0];
					default: ;
				endcase
			end
			if (blend_valid && !blend_stall) begin
				blend_valid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (base_acc) begin
						state_q <= S_HDR;
					end
					if (restart_acc) begin
						rp_a_q <= '0;
						rp_b_q <= '0;
						vpos_q <= '0;
					end
				end
				S_HDR:   state_q <= S_X;
				S_X:     state_q <= S_Y;
				S_Y:     state_q <= S_Z;
				S_Z:     state_q <= S_ADD;
				S_ADD:   state_q <= S_FIN;
				S_FIN: begin
					if (out_free) begin
						blend_valid <= 1'b1;
						blend.out_x <= res_q[0];
						blend.out_y <= res_q[1];
						blend.out_z <= res_q[2];
						if (use_a_q) begin
							rp_a_q <= ptr_a_q;
						end
						if (use_b_q) begin
							rp_b_q <= ptr_b_q;
						end
						vpos_q  <= chunk_end_q ? 16'd0 : vpos_q + 16'd1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`SMTB_ASSERT_NEXT(a_base_busy, base_acc, state_q == S_HDR && item_stall,
		"base vertex request did not start the fetch sequence")
	`SMTB_ASSERT_NEXT(a_rp_a_hold, state_q != S_FIN && !restart_acc, $stable(rp_a_q),
		"stream A read pointer moved outside vertex completion or restart")
	`SMTB_ASSERT_NEXT(a_rp_b_hold, state_q != S_FIN && !restart_acc, $stable(rp_b_q),
		"stream B read pointer moved outside vertex completion or restart")
	`SMTB_ASSERT_NEXT(a_out_source, state_q != S_FIN && !blend_valid, !blend_valid,
		"result appeared without a completed vertex")

endmodule

`default_nettype wire

### dv/sparse_morph_target_blend_top_test.sv
// ----------------------------------------------------------------------------
// sparse_morph_target_blend_top_test
// Self-checking bench for the two-stream morph blend block. Stream words,
// base vertices and restarts go in through a queue-fed driver; every accepted
// request updates a local model of the stream memories, read pointers and
// vertex position, which predicts each blended vertex. A monitor compares
// returned vertices field by field. Runs a short directed set, randomized
// stream/chunk scenes under several register settings, and a closing stretch
// with no idling.
// ----------------------------------------------------------------------------

module sparse_morph_target_blend_top_test
	import smtb_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_ITEMS = 850;
	localparam int TAIL_ITEMS   = 100;
	localparam int SETTLE       = 12;
	localparam int QUIET_LIMIT  = 2000;

	localparam logic [CFG_IW-1:0] REG_SPARE = 2'd2;

	logic              clk;
	logic              arst_n      = 1'b0;
	logic              item_valid  = 1'b0;
	logic              item_stall;
	item_t             item        = '0;
	logic              cfg_valid   = 1'b0;
	logic              cfg_ready;
	logic [CFG_IW-1:0] cfg_index   = '0;
	logic [16:0]       cfg_data    = '0;
	logic              blend_valid;
	logic              blend_stall = 1'b0;
	blend_t            blend;

	// request side
	item_t pending_items[$];
	int    items_queued = 0;
	int    gap_left     = 0;
	int    stall_left   = 0;
	int    idle_mode    = 0;
	logic  item_fired   = 1'b0;
	logic  cfg_fired    = 1'b0;
	int    plan_first   = 0;

	// blend model
	logic [15:0] mem_a [STREAM_WORDS];
	logic [15:0] mem_b [STREAM_WORDS];
	logic [11:0] rd_a      = '0;
	logic [11:0] rd_b      = '0;
	logic [15:0] chunk_pos = '0;
	logic [16:0] wgt_b     = '0;
	logic [15:0] fvert     = '0;
	blend_t      blend_expected[$];

	int mismatches = 0;
	int quiet      = 0;

	sparse_morph_target_blend_top u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.blend_valid(blend_valid),
		.blend_stall(blend_stall),
		.blend      (blend)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [31:0] widen(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

	function automatic logic [2:0][15:0] pop_stream_entry(input bit from_b);
		logic [11:0]      p;
		logic [15:0]      hdr;
		logic [2:0][15:0] d;
		p = from_b ? rd_b : rd_a;
		hdr = from_b ? mem_b[p] : mem_a[p];
		d = '0;
		p = p + 12'd1;
		for (int k = 0; k < 3; k++) begin
			if (hdr[13 + k]) begin
				d[k] = from_b ? mem_b[p] : mem_a[p];
				p = p + 12'd1;
			end
		end
		if (from_b)
			rd_b = p;
		else
			rd_a = p;
		return d;
	endfunction

	task automatic blend_predict(input item_t it);
		logic [2:0][15:0] da;
		logic [2:0][15:0] db;
		logic [2:0][15:0] base;
		logic [2:0][15:0] outv;
		logic [31:0]      wa;
		logic [31:0]      r;
		int               pos;
		int               ia;
		int               ib;
		bit               take_a;
		bit               take_b;
		blend_t           res;
		case (it.kind)
			KIND_WR_A: mem_a[it.address] = it.word;
			KIND_WR_B: mem_b[it.address] = it.word;
			KIND_RESTART: begin
				rd_a = '0;
				rd_b = '0;
				chunk_pos = '0;
			end
			default: begin
				base = {it.base_z, it.base_y, it.base_x};
				da = '0;
				db = '0;
				pos = int'(chunk_pos);
				ia = int'(mem_a[rd_a][12:0]) - int'(fvert);
				ib = int'(mem_b[rd_b][12:0]) - int'(fvert);
				take_a = pos >= ia;
				take_b = take_a ? (pos == ib) : (pos >= ib);
				if (take_b)
					db = pop_stream_entry(1'b1);
				if (take_a)
					da = pop_stream_entry(1'b0);
				wa = 32'h10000 - 32'(wgt_b);
				for (int k = 0; k < 3; k++) begin
					if (take_a || take_b)
						r = ((widen(da[k]) * wa + widen(db[k]) * 32'(wgt_b)) >> 16)
							+ widen(base[k]);
					else
						r = widen(base[k]);
					outv[k] = r[15:0];
				end
				res.out_x = outv[0];
				res.out_y = outv[1];
				res.out_z = outv[2];
				blend_expected.push_back(res);
				chunk_pos = it.chunk_end ? 16'd0 : chunk_pos + 16'd1;
			end
		endcase
	endtask

	task automatic report_mismatch(input string what, input logic [15:0] got,
			input logic [15:0] want);
		if (mismatches < 100)
			$display("%0t blend %s: got %h, want %h", $time, what, got, want);
		mismatches++;
	endtask

	// request driver
	always @(negedge clk) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else if (!item_valid || item_fired) begin
			if (gap_left > 0) begin
				gap_left--;
				item_valid <= 1'b0;
			end else if (pending_items.size() != 0) begin
				item <= pending_items.pop_front();
				item_valid <= 1'b1;
				if (idle_mode != 0 && $urandom_range(0, idle_mode == 1 ? 9 : 3) == 0)
					gap_left = $urandom_range(1, 6);
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// result back-pressure
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			blend_stall <= 1'b1;
		end else if (idle_mode != 0 && $urandom_range(0, idle_mode == 1 ? 9 : 3) == 0) begin
			stall_left = $urandom_range(0, 5);
			blend_stall <= 1'b1;
		end else begin
			blend_stall <= 1'b0;
		end
	end

	// monitor
	always @(posedge clk) begin
		blend_t want;
		if (arst_n) begin
			item_fired <= item_valid && !item_stall;
			cfg_fired <= cfg_valid && cfg_ready;
			if ((item_valid && !item_stall) || (cfg_valid && cfg_ready)
					|| (blend_valid && !blend_stall))
				quiet <= 0;
			else
				quiet <= quiet + 1;
			if (blend_valid && !blend_stall) begin
				if (blend_expected.size() == 0) begin
					report_mismatch("unexpected result out_x", blend.out_x, 16'h0);
				end else begin
					want = blend_expected.pop_front();
					if (blend.out_x !== want.out_x)
						report_mismatch("out_x", blend.out_x, want.out_x);
					if (blend.out_y !== want.out_y)
						report_mismatch("out_y", blend.out_y, want.out_y);
					if (blend.out_z !== want.out_z)
						report_mismatch("out_z", blend.out_z, want.out_z);
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_WEIGHT_B:     wgt_b = cfg_data;
					REG_FIRST_VERTEX: fvert = cfg_data[15:0];
					default: ;
				endcase
			end
			if (item_valid && !item_stall)
				blend_predict(item);
		end
	end

	always @(posedge clk) begin
		if (quiet >= QUIET_LIMIT) begin
			$display("sparse_morph_target_blend_top: mismatch");
			$finish;
		end
	end

	function automatic logic [15:0] pick_word();
		case ($urandom_range(0, 7))
			0:       return 16'h8000;
			1:       return 16'h7fff;
			2:       return 16'hffff;
			3:       return 16'h0000;
			default: return 16'($urandom());
		endcase
	endfunction

	function automatic void queue_item(input kind_t k, input logic [11:0] a,
			input logic [15:0] w, input logic [15:0] x, input logic [15:0] y,
			input logic [15:0] z, input logic ce);
		item_t it;
		it.kind = k;
		it.address = a;
		it.word = w;
		it.base_x = x;
		it.base_y = y;
		it.base_z = z;
		it.chunk_end = ce;
		pending_items.push_back(it);
		items_queued++;
	endfunction

	function automatic void push_word(input kind_t k, input logic [11:0] a,
			input logic [15:0] w);
		queue_item(k, a, w, pick_word(), pick_word(), pick_word(), 1'($urandom()));
	endfunction

	function automatic void push_vertex(input logic [15:0] x, input logic [15:0] y,
			input logic [15:0] z, input logic ce);
		queue_item(KIND_BASE, 12'($urandom()), 16'($urandom()), x, y, z, ce);
	endfunction

	function automatic void push_restart();
		queue_item(KIND_RESTART, 12'($urandom()), 16'($urandom()), pick_word(),
			pick_word(), pick_word(), 1'($urandom()));
	endfunction

	// one stream laid out from address 0, as many entries as vertices, closed by
	// an index past every vertex when one fits in 13 bits, else a random one
	function automatic void write_stream(input kind_t k, input int nv);
		int          ne;
		int          idx;
		logic [11:0] a;
		logic [2:0]  flags;
		logic [12:0] hdr;
		ne = nv;
		idx = -1;
		a = '0;
		for (int e = 0; e <= ne; e++) begin
			flags = 3'($urandom());
			if (e == ne) begin
				if (plan_first + nv <= 8191)
					hdr = 13'(plan_first + nv + $urandom_range(0, 8191 - plan_first - nv));
				else
					hdr = 13'($urandom());
			end else begin
				if ($urandom_range(0, 3) == 0)
					idx = int'($urandom_range(0, nv)) - 1;
				else
					idx = idx + int'($urandom_range(0, 2));
				hdr = 13'(plan_first + idx);
			end
			push_word(k, a, {flags, hdr});
			a = a + 12'd1;
			for (int c = 0; c < 3; c++) begin
				if (flags[c]) begin
					push_word(k, a, pick_word());
					a = a + 12'd1;
				end
			end
		end
	endfunction

	function automatic void add_scene();
		int nv;
		nv = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
		push_restart();
		write_stream(KIND_WR_A, nv);
		write_stream(KIND_WR_B, nv);
		for (int v = 0; v < nv; v++) begin
			case ($urandom_range(0, 19))
				0: push_word(KIND_WR_A, 12'($urandom_range(256, 4095)), 16'($urandom()));
				1: push_word(KIND_WR_B, 12'($urandom_range(256, 4095)), 16'($urandom()));
				2: if ($urandom_range(0, 3) == 0) push_restart();
				default: ;
			endcase
			push_vertex(pick_word(), pick_word(), pick_word(),
				(v == nv - 1) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 15) == 0));
		end
	endfunction

	task automatic cfg_write(input logic [CFG_IW-1:0] idx, input logic [16:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(negedge clk); while (!cfg_fired);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_config(input logic [16:0] w, input logic [15:0] fv);
		if ($urandom_range(0, 1)) begin
			cfg_write(REG_WEIGHT_B, w);
			cfg_write(REG_FIRST_VERTEX, 17'(fv));
		end else begin
			cfg_write(REG_FIRST_VERTEX, 17'(fv));
			cfg_write(REG_WEIGHT_B, w);
		end
		if ($urandom_range(0, 2) == 0)
			cfg_write(REG_SPARE | 2'($urandom_range(0, 1)), 17'($urandom()));
		plan_first = int'(fv);
	endtask

	task automatic drain();
		do @(negedge clk);
		while (pending_items.size() != 0 || item_valid || blend_expected.size() != 0);
		repeat (SETTLE) @(negedge clk);
	endtask

	initial begin
		int          phase;
		int          phase_end;
		int          random_start;
		logic [16:0] w;
		logic [15:0] fv;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: both streams, each consumption case, coordinate extremes
		set_config(17'h04000, 16'd0);
		push_restart();
		push_word(KIND_WR_A, 12'd0, {3'b111, 13'd0});
		push_word(KIND_WR_A, 12'd1, 16'h8000);
		push_word(KIND_WR_A, 12'd2, 16'h7fff);
		push_word(KIND_WR_A, 12'd3, 16'hffff);
		push_word(KIND_WR_A, 12'd4, {3'b001, 13'd2});
		push_word(KIND_WR_A, 12'd5, 16'h0001);
		push_word(KIND_WR_A, 12'd6, {3'b000, 13'h1fff});
		push_word(KIND_WR_B, 12'd0, {3'b010, 13'd0});
		push_word(KIND_WR_B, 12'd1, 16'h7fff);
		push_word(KIND_WR_B, 12'd2, {3'b000, 13'd1});
		push_word(KIND_WR_B, 12'd3, {3'b000, 13'h1fff});
		push_vertex(16'h8000, 16'h7fff, 16'h0000, 1'b0);
		push_vertex(16'h7fff, 16'h8000, 16'hffff, 1'b0);
		push_vertex(16'hffff, 16'h0001, 16'h1234, 1'b0);
		push_vertex(16'h7fff, 16'h8000, 16'h0000, 1'b1);
		push_restart();
		drain();

		random_start = items_queued;
		phase = 0;
		while (items_queued < random_start + RANDOM_ITEMS) begin
			case (phase)
				0: begin w = 17'h00000; fv = 16'hffff; end
				1: begin w = 17'h10000; fv = 16'h0000; end
				2: begin w = 17'h1ffff; fv = 16'h1fff; end
				default: begin
					case ($urandom_range(0, 5))
						0:       w = 17'h00000;
						1:       w = 17'h10000;
						2:       w = 17'h1ffff;
						3:       w = 17'h08000;
						4:       w = 17'($urandom_range(0, 65536));
						default: w = 17'($urandom());
					endcase
					case ($urandom_range(0, 5))
						0:       fv = 16'h0000;
						1:       fv = 16'hffff;
						2:       fv = 16'($urandom_range(0, 40));
						3:       fv = 16'($urandom_range(0, 8191));
						4:       fv = 16'(8191 - $urandom_range(0, 30));
						default: fv = 16'($urandom());
					endcase
				end
			endcase
			set_config(w, fv);
			idle_mode = (phase == 1) ? 0 : $urandom_range(0, 2);
			phase_end = items_queued + $urandom_range(80, 220);
			while (items_queued < phase_end)
				add_scene();
			drain();
			phase++;
		end

		// closing stretch with no idling
		idle_mode = 0;
		set_config(17'($urandom_range(0, 65536)), 16'($urandom_range(0, 40)));
		phase_end = items_queued + TAIL_ITEMS;
		while (items_queued < phase_end)
			add_scene();
		drain();

		if (mismatches == 0)
			$display("sparse_morph_target_blend_top: match");
		else
			$display("sparse_morph_target_blend_top: mismatch");
		$finish;
	end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/smtb_pkg.sv
hw/rtl/sparse_morph_target_blend_top.sv
dv/sparse_morph_target_blend_top_test.sv
